// ===== hw/rtl/ptwm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwm_pkg
// shared types, codes and helpers for the page-table walker
// ----------------------------------------------------------------------------
package ptwm_pkg;

    localparam int TABLE_WORDS_DEF = 4096;

    localparam int PA_W   = 52;
    localparam int VA_W   = 57;
    localparam int WORD_W = 64;
    localparam int IDX_W  = 9;

    // transaction kinds
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_TRANSLATE = 2'd1;
    localparam logic [1:0] KIND_MAP       = 2'd2;

    // result status codes, a fault code is the level of the missing entry
    localparam logic [2:0] STATUS_OK = 3'd0;
    localparam logic [2:0] LEVEL_LEAF = 3'd1;
    localparam logic [2:0] LEVEL_TOP4 = 3'd4;
    localparam logic [2:0] LEVEL_TOP5 = 3'd5;

    localparam int PROT_SHIFT = 59;

    localparam logic [5:0] PA_BITS_MIN = 6'd32;
    localparam logic [5:0] PA_BITS_MAX = 6'd52;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // nine-bit table index of a virtual address at a given level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [2:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            3'd1:    idx = va[20:12];
            3'd2:    idx = va[29:21];
            3'd3:    idx = va[38:30];
            3'd4:    idx = va[47:39];
            3'd5:    idx = va[56:48];
            default: idx = '0;
        endcase
        return idx;
    endfunction

    // frame mask: bits 12 .. phys_addr_bits-1, width clamped to 32..52
    function automatic logic [PA_W-1:0] frame_mask(input logic [5:0] bits);
        logic [5:0]    clamped;
        logic [PA_W:0] ones;
        clamped = bits;
        if (bits < PA_BITS_MIN)
        begin
            clamped = PA_BITS_MIN;
        end
        if (bits > PA_BITS_MAX)
        begin
            clamped = PA_BITS_MAX;
        end
        ones = ((PA_W + 1)'(1) << clamped) - (PA_W + 1)'(1);
        return ones[PA_W-1:0] & ~(PA_W)'(12'hFFF);
    endfunction

endpackage

// ===== hw/rtl/ptwm_store.sv =====
// ----------------------------------------------------------------------------
// ptwm_store
// table store: single-port synchronous memory, registered read
// ----------------------------------------------------------------------------
module ptwm_store
    import ptwm_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_WORDS_DEF,
    localparam int AW = $clog2(TABLE_WORDS)
)
(
    input  logic              clk,
    input  mem_ctl_t          mem_ctl,
    input  logic [AW-1:0]     mem_addr,
    input  logic [WORD_W-1:0] mem_wdata,
    output logic [WORD_W-1:0] mem_rdata
);

    logic [WORD_W-1:0] mem [TABLE_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

// ===== hw/rtl/ptwm_walk.sv =====
// ----------------------------------------------------------------------------
// ptwm_walk
// walk sequencer: one table read per level, leaf read-modify-write for map
// ----------------------------------------------------------------------------
module ptwm_walk
    import ptwm_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_WORDS_DEF,
    localparam int AW = $clog2(TABLE_WORDS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PA_W-1:0]   root_base,
    input  logic [5:0]        phys_addr_bits,
    input  logic              five_level,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [WORD_W-1:0] data_word,
    input  logic [7:0]        page_flags,
    input  logic [4:0]        protection,
    output logic              done,
    output logic [2:0]        status,
    output logic [PA_W-1:0]   phys_addr,
    output mem_ctl_t          mem_ctl,
    output logic [AW-1:0]     mem_addr,
    output logic [WORD_W-1:0] mem_wdata,
    input  logic [WORD_W-1:0] mem_rdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              state_reg, state_next;
    logic [2:0]        level_reg, level_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [PA_W-1:0]   phys_reg, phys_next;
    logic              is_map_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PA_W-1:0]   frame_reg;
    logic [7:0]        flags_reg;
    logic [4:0]        prot_reg;

    logic              accept;
    logic [PA_W-1:0]   mask;
    logic [2:0]        top_level;
    logic [WORD_W-1:0] leaf_word;

    // word slot of entry idx in the table at base, wraps with the store size
    function automatic logic [AW-1:0] slot_of(input logic [PA_W-1:0] base,
                                              input logic [IDX_W-1:0] idx);
        logic [AW-1:0] base_word;
        base_word = AW'(base >> 3);
        return base_word + AW'(idx);
    endfunction

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign mask      = frame_mask(phys_addr_bits);
    assign top_level = five_level ? LEVEL_TOP5 : LEVEL_TOP4;

    assign leaf_word = mem_rdata
                     | WORD_W'(1)
                     | (WORD_W'(flags_reg) << 1)
                     | WORD_W'(frame_reg & mask)
                     | (WORD_W'(prot_reg) << PROT_SHIFT);

    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        phys_next   = phys_reg;
        mem_ctl     = '0;
        mem_addr    = addr_reg;
        mem_wdata   = leaf_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind) inside
                        KIND_WRITE:
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_addr      = virt_addr[AW+2:3];
                            mem_wdata     = data_word;
                            done_next     = 1'b1;
                            status_next   = STATUS_OK;
                            phys_next     = '0;
                        end
                        KIND_TRANSLATE, KIND_MAP:
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_addr      = slot_of(root_base & mask,
                                                    level_index(virt_addr, top_level));
                            addr_next     = mem_addr;
                            level_next    = top_level;
                            state_next    = ST_WALK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_OK;
                            phys_next   = '0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (level_reg == LEVEL_LEAF && is_map_reg)
                begin
                    // leaf read-modify-write, no present check on the leaf
                    mem_ctl.wr_en = 1'b1;
                    mem_addr      = addr_reg;
                    mem_wdata     = leaf_word;
                    done_next     = 1'b1;
                    status_next   = STATUS_OK;
                    phys_next     = '0;
                    state_next    = ST_IDLE;
                end
                else if (!mem_rdata[0])
                begin
                    done_next   = 1'b1;
                    status_next = level_reg;
                    phys_next   = '0;
                    state_next  = ST_IDLE;
                end
                else if (level_reg == LEVEL_LEAF)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    phys_next   = mem_rdata[PA_W-1:0] & mask;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // next level table base comes straight from the entry
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = slot_of(mem_rdata[PA_W-1:0] & mask,
                                            level_index(va_reg, level_reg - 3'd1));
                    addr_next     = mem_addr;
                    level_next    = level_reg - 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= LEVEL_LEAF;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        status_reg <= status_next;
        phys_reg   <= phys_next;
        if (accept)
        begin
            is_map_reg <= (kind == KIND_MAP);
            va_reg     <= virt_addr;
            frame_reg  <= data_word[PA_W-1:0];
            flags_reg  <= page_flags;
            prot_reg   <= protection;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign phys_addr = phys_reg;

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("store read and write in the same cycle");

    a_walk_write_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && mem_ctl.wr_en) |-> (level_reg == LEVEL_LEAF && is_map_reg))
        else $error("walk wrote the store away from a map leaf");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (level_reg >= LEVEL_LEAF && level_reg <= LEVEL_TOP5))
        else $error("walk level out of range");

    a_read_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |=> (state_reg == ST_WALK))
        else $error("store read data arrived outside the walk");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a walk is still running");

endmodule

// ===== hw/rtl/page_table_walk_and_map.sv =====
// ----------------------------------------------------------------------------
// page_table_walk_and_map
// x86-64 style four/five-level page-table walker over an internal table store
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one result
// comes back on done/status/phys_addr, valid for a single cycle, and the
// receiver cannot stall it. For a write or an unknown kind the strobe shows
// in the next cycle and busy never rises. Translate and map read one table
// entry per level through the single store port, each read depending on the
// entry before it, so they keep busy high while they walk the levels; a walk
// that faults ends at the faulting level. The next transaction can be taken
// only once busy is low again. The map leaf update is a read-modify-write on
// the leaf slot in the last walk cycle. The store has no reset; reading a
// word that was never written gives undefined data. TABLE_WORDS must be a
// power of two.
// Configuration (APB, 64-bit data, write only while idle):
//   0x00 root_base, 0x08 phys_addr_bits, 0x10 five_level
// ----------------------------------------------------------------------------
module page_table_walk_and_map
    import ptwm_pkg::*;
#(
    parameter int TABLE_WORDS = TABLE_WORDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    // transaction request
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [WORD_W-1:0] data_word,
    input  logic [7:0]        page_flags,
    input  logic [4:0]        protection,
    // result
    output logic              done,
    output logic [2:0]        status,
    output logic [PA_W-1:0]   phys_addr
);

    localparam int AW = $clog2(TABLE_WORDS);

    // register index is paddr[4:3]
    localparam logic [1:0] REG_ROOT_BASE = 2'd0;
    localparam logic [1:0] REG_PA_BITS   = 2'd1;
    localparam logic [1:0] REG_FIVE_LVL  = 2'd2;

    logic [PA_W-1:0]   root_base_reg;
    logic [5:0]        pa_bits_reg;
    logic              five_level_reg;
    logic              cfg_write;
    logic [1:0]        reg_index;

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_base_reg  <= '0;
            pa_bits_reg    <= PA_BITS_MAX;
            five_level_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_ROOT_BASE: root_base_reg  <= pwdata[PA_W-1:0];
                REG_PA_BITS:   pa_bits_reg    <= pwdata[5:0];
                REG_FIVE_LVL:  five_level_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_index)
            REG_ROOT_BASE: prdata = 64'(root_base_reg);
            REG_PA_BITS:   prdata = 64'(pa_bits_reg);
            REG_FIVE_LVL:  prdata = 64'(five_level_reg);
            default:       prdata = '0;
        endcase
    end

    // walk sequencer, owns the single store port
    ptwm_walk #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .root_base      (root_base_reg),
        .phys_addr_bits (pa_bits_reg),
        .five_level     (five_level_reg),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .virt_addr      (virt_addr),
        .data_word      (data_word),
        .page_flags     (page_flags),
        .protection     (protection),
        .done           (done),
        .status         (status),
        .phys_addr      (phys_addr),
        .mem_ctl        (mem_ctl),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    // table store
    ptwm_store #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_store (
        .clk       (clk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule

// ===== test/page_table_walk_and_map_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_table_walk_and_map_test
// self-checking bench for the page-table walker: walks are kept to sixteen
// table indices per level and every store word they can reach is written
// first, then it builds walk chains, injects missing entries at every level,
// runs mixed write/translate/map traffic under several register settings and
// checks each result against a cycle-free software copy of the walker
// ----------------------------------------------------------------------------
module page_table_walk_and_map_test;
    import ptwm_pkg::*;

    localparam int TABLE_WORDS = TABLE_WORDS_DEF;
    localparam int WORD_BITS   = $clog2(TABLE_WORDS);
    // number of page-select bits above the 512-entry table index
    localparam int PAGE_BITS   = WORD_BITS - IDX_W;
    localparam int INDEX_PICKS = 16;
    localparam int MAX_GAP     = 14;
    localparam int STALL_LIMIT = 1000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // register byte addresses, 64-bit register map
    localparam logic [4:0] REG_ROOT_BASE  = 5'h00;
    localparam logic [4:0] REG_PA_BITS    = 5'h08;
    localparam logic [4:0] REG_FIVE_LEVEL = 5'h10;

    localparam logic [WORD_W-1:0] PRESENT_BIT = 64'd1;

    // one pending transaction plus the idle cycles that come before it
    typedef struct packed {
        logic [3:0]        gap;
        logic [1:0]        kind;
        logic [VA_W-1:0]   va;
        logic [WORD_W-1:0] data;
        logic [7:0]        flags;
        logic [4:0]        prot;
    } walk_req_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [PA_W-1:0] pa;
    } walk_res_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    // transaction request
    logic              start      = 1'b0;
    logic              busy;
    logic [1:0]        kind       = '0;
    logic [VA_W-1:0]   virt_addr  = '0;
    logic [WORD_W-1:0] data_word  = '0;
    logic [7:0]        page_flags = '0;
    logic [4:0]        protection = '0;

    // result
    logic            done;
    logic [2:0]      status;
    logic [PA_W-1:0] phys_addr;

    page_table_walk_and_map dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .virt_addr  (virt_addr),
        .data_word  (data_word),
        .page_flags (page_flags),
        .protection (protection),
        .done       (done),
        .status     (status),
        .phys_addr  (phys_addr)
    );

    // software copy of the block: table contents and register values
    logic [WORD_W-1:0] table_mirror [TABLE_WORDS];
    logic [PA_W-1:0]   root_base_m  = '0;
    logic [5:0]        pa_bits_m    = PA_BITS_MAX;
    logic              five_level_m = 1'b0;

    walk_req_t req_backlog [$];
    walk_res_t results_due [$];

    // driver state
    walk_req_t  held_req;
    walk_req_t  next_req;
    logic       holding  = 1'b0;
    logic [3:0] hold_cnt = '0;

    int gap_max     = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int chain_slot [1:5];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        return VA_W'(rand64());
    endfunction

    // one of sixteen table indices, spread from 0 to 511
    function automatic logic [IDX_W-1:0] pick_index(input logic [3:0] sel);
        return {sel[3], sel[3], sel[3], sel[2], sel[2], sel[2], sel[1], sel[1], sel[0]};
    endfunction

    // random virtual address whose index at every level is a picked one
    function automatic logic [VA_W-1:0] walk_va();
        logic [VA_W-1:0] va;
        int              lvl;
        va = rand_va();
        for (lvl = 1; lvl <= 5; lvl++)
        begin
            va[12 + 9 * (lvl - 1) +: IDX_W] = pick_index(4'($urandom));
        end
        return va;
    endfunction

    // frame bits 12 .. width-1, width held to the legal range
    function automatic logic [PA_W-1:0] pa_mask();
        int n;
        n = int'(pa_bits_m);
        if (n < int'(PA_BITS_MIN))
        begin
            n = int'(PA_BITS_MIN);
        end
        if (n > int'(PA_BITS_MAX))
        begin
            n = int'(PA_BITS_MAX);
        end
        return ({PA_W{1'b1}} >> (PA_W - n)) & ~PA_W'(12'hFFF);
    endfunction

    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va, input int lvl);
        return IDX_W'(va >> (12 + 9 * (lvl - 1)));
    endfunction

    // store word of entry idx in the table at base, wrapping at the store size
    function automatic int slot_of(input logic [PA_W-1:0] base, input logic [IDX_W-1:0] idx);
        logic [63:0] w;
        w = (64'(base) >> 3) + 64'(idx);
        return int'(w % TABLE_WORDS);
    endfunction

    // byte address of a store word, random bits outside the word index
    function automatic logic [VA_W-1:0] word_addr(input int slot);
        logic [VA_W-1:0] va;
        va = rand_va();
        va[3 +: WORD_BITS] = WORD_BITS'(slot);
        return va;
    endfunction

    // walks the mirror table the way the block does, applies writes and map
    // updates, and returns the result the block must give
    function automatic walk_res_t walk_and_update(input logic [1:0]        k,
                                                  input logic [VA_W-1:0]   va,
                                                  input logic [WORD_W-1:0] data,
                                                  input logic [7:0]        flags,
                                                  input logic [4:0]        prot);
        walk_res_t         r;
        logic [PA_W-1:0]   mask;
        logic [PA_W-1:0]   base;
        logic [WORD_W-1:0] e;
        logic [2:0]        fault;
        int                lvl;
        int                top;
        int                leaf;
        r.status = STATUS_OK;
        r.pa     = '0;
        mask     = pa_mask();
        fault    = '0;
        if (k == KIND_WRITE)
        begin
            table_mirror[int'((va >> 3) % TABLE_WORDS)] = data;
        end
        else if (k == KIND_TRANSLATE || k == KIND_MAP)
        begin
            top  = five_level_m ? 5 : 4;
            base = root_base_m & mask;
            for (lvl = top; lvl >= 2 && fault == 0; lvl--)
            begin
                e = table_mirror[slot_of(base, va_index(va, lvl))];
                if (e[0] == 1'b0)
                begin
                    fault = 3'(lvl);
                end
                else
                begin
                    base = e[PA_W-1:0] & mask;
                end
            end
            if (fault != 0)
            begin
                r.status = fault;
            end
            else
            begin
                leaf = slot_of(base, va_index(va, 1));
                if (k == KIND_TRANSLATE)
                begin
                    e = table_mirror[leaf];
                    if (e[0] == 1'b0)
                    begin
                        r.status = LEVEL_LEAF;
                    end
                    else
                    begin
                        r.pa = e[PA_W-1:0] & mask;
                    end
                end
                else
                begin
                    table_mirror[leaf] = table_mirror[leaf] | PRESENT_BIT
                                       | (64'(flags) << 1)
                                       | 64'(data[PA_W-1:0] & mask)
                                       | (64'(prot) << PROT_SHIFT);
                end
            end
        end
        return r;
    endfunction

    // present one transaction on the request ports
    task automatic drive_req(input walk_req_t q);
        start      <= 1'b1;
        kind       <= q.kind;
        virt_addr  <= q.va;
        data_word  <= q.data;
        page_flags <= q.flags;
        protection <= q.prot;
    endtask

    // idle cycle: start low, junk on the payload
    task automatic drive_noise();
        start      <= 1'b0;
        kind       <= 2'($urandom);
        virt_addr  <= rand_va();
        data_word  <= rand64();
        page_flags <= 8'($urandom);
        protection <= 5'($urandom);
    endtask

    // driver: a transaction is taken at an edge with start high and busy low;
    // the expected result is worked out at that same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            holding  <= 1'b0;
            hold_cnt <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                results_due.push_back(walk_and_update(kind, virt_addr, data_word,
                                                      page_flags, protection));
            end
            if (holding)
            begin
                if (hold_cnt == 0)
                begin
                    drive_req(held_req);
                    holding <= 1'b0;
                end
                else
                begin
                    hold_cnt <= hold_cnt - 4'd1;
                    drive_noise();
                end
            end
            else if (req_backlog.size() != 0)
            begin
                next_req = req_backlog.pop_front();
                if (next_req.gap == 0)
                begin
                    drive_req(next_req);
                end
                else
                begin
                    held_req <= next_req;
                    hold_cnt <= next_req.gap - 4'd1;
                    holding  <= 1'b1;
                    drive_noise();
                end
            end
            else
            begin
                drive_noise();
            end
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        walk_res_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: status %0d phys_addr %h", status, phys_addr);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
                if (phys_addr !== want.pa)
                begin
                    $error("phys_addr: expected %h, actual %h", want.pa, phys_addr);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request nor a result transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[page_table_walk_and_map] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(input logic [1:0]        k,
                            input logic [VA_W-1:0]   va,
                            input logic [WORD_W-1:0] data,
                            input logic [7:0]        flags,
                            input logic [4:0]        prot);
        walk_req_t q;
        q.gap   = 4'($urandom_range(gap_max, 0));
        q.kind  = k;
        q.va    = va;
        q.data  = data;
        q.flags = flags;
        q.prot  = prot;
        req_backlog.push_back(q);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [4:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_ROOT_BASE:  root_base_m  = value[PA_W-1:0];
            REG_PA_BITS:    pa_bits_m    = value[5:0];
            REG_FIVE_LEVEL: five_level_m = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait until every queued transaction is taken and answered, then let the
    // block settle before touching its registers
    task automatic drain();
        while (req_backlog.size() != 0 || holding || start || results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // writes a complete present chain for va, one table page per level,
    // and remembers the store word of every level
    task automatic build_chain(input logic [VA_W-1:0] va);
        logic [PA_W-1:0]   base;
        logic [WORD_W-1:0] entry;
        int                top;
        int                lvl;
        int                page;
        top  = five_level_m ? 5 : 4;
        base = root_base_m & pa_mask();
        page = int'(base[12 +: PAGE_BITS]);
        for (lvl = top; lvl >= 1; lvl--)
        begin
            chain_slot[lvl] = slot_of(base, va_index(va, lvl));
            page  = (page + 1) % (1 << PAGE_BITS);
            entry = rand64();
            entry[0] = 1'b1;
            entry[12 +: PAGE_BITS] = PAGE_BITS'(page);
            push_req(KIND_WRITE, word_addr(chain_slot[lvl]), entry, 8'($urandom),
                     5'($urandom));
            base = entry[PA_W-1:0] & pa_mask();
        end
    endtask

    // mixed traffic, mostly present entries so walks often reach the leaf
    task automatic random_burst(input int count);
        logic [WORD_W-1:0] d;
        int                n;
        int                pick;
        for (n = 0; n < count; n++)
        begin
            // stretches with and without idle cycles
            if (n % 25 == 0)
            begin
                gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
            end
            pick = $urandom_range(99, 0);
            d    = rand64();
            if (pick < 22)
            begin
                d[0] = ($urandom_range(9, 0) < 8);
                push_req(KIND_WRITE, rand_va(), d, 8'($urandom), 5'($urandom));
            end
            else if (pick < 60)
            begin
                push_req(KIND_TRANSLATE, walk_va(), d, 8'($urandom), 5'($urandom));
            end
            else if (pick < 96)
            begin
                push_req(KIND_MAP, walk_va(), d, 8'($urandom), 5'($urandom));
            end
            else
            begin
                push_req(KIND_UNUSED, rand_va(), d, 8'($urandom), 5'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [VA_W-1:0]   va;
        logic [WORD_W-1:0] w;
        int                i;
        int                lvl;
        int                page;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: every store word a walk can reach gets written once,
        // so no walk ever reads an undefined entry; most entries are present
        gap_max = 0;
        for (page = 0; page < (1 << PAGE_BITS); page++)
        begin
            for (i = 0; i < INDEX_PICKS; i++)
            begin
                w    = rand64();
                w[0] = ($urandom_range(7, 0) != 0);
                push_req(KIND_WRITE,
                         word_addr(page * (1 << IDX_W) + int'(pick_index(4'(i)))),
                         w, 8'($urandom), 5'($urandom));
            end
        end

        // four-level chain: hit, map with all-ones fields, extremes of va
        gap_max = MAX_GAP;
        va = walk_va();
        build_chain(va);
        push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
        push_req(KIND_MAP, va, '1, 8'hFF, 5'h1F);
        push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
        push_req(KIND_TRANSLATE, '1, '1, 8'hFF, 5'h1F);
        push_req(KIND_MAP, '0, '0, 8'h00, 5'h00);
        push_req(KIND_UNUSED, rand_va(), rand64(), 8'($urandom), 5'($urandom));

        // knock out the chain from the leaf upward, one missing level at a time
        for (lvl = 1; lvl <= 4; lvl++)
        begin
            w    = rand64();
            w[0] = 1'b0;
            push_req(KIND_WRITE, word_addr(chain_slot[lvl]), w, 8'($urandom), 5'($urandom));
            push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
            if (lvl == 3)
            begin
                // map over a missing upper level must leave the table alone
                push_req(KIND_MAP, va, rand64(), 8'($urandom), 5'($urandom));
            end
        end
        random_burst(80);
        drain();

        // largest root base, narrowest address, five-level walk; junk above
        // each register's width
        w = rand64();
        w[PA_W-1:0] = '1;
        apb_write(REG_ROOT_BASE, w);
        apb_write(REG_PA_BITS, {58'(rand64()), PA_BITS_MIN});
        apb_write(REG_FIVE_LEVEL, {63'(rand64()), 1'b1});

        gap_max = MAX_GAP;
        va = walk_va();
        build_chain(va);
        push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
        push_req(KIND_MAP, va, rand64(), 8'($urandom), 5'($urandom));
        push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
        // top-level entry missing
        w    = rand64();
        w[0] = 1'b0;
        push_req(KIND_WRITE, word_addr(chain_slot[5]), w, 8'($urandom), 5'($urandom));
        push_req(KIND_TRANSLATE, va, rand64(), 8'($urandom), 5'($urandom));
        push_req(KIND_MAP, va, rand64(), 8'($urandom), 5'($urandom));
        random_burst(80);
        drain();

        // width below the legal range, four-level
        apb_write(REG_ROOT_BASE, rand64());
        apb_write(REG_PA_BITS, {58'(rand64()), 6'd0});
        apb_write(REG_FIVE_LEVEL, {63'(rand64()), 1'b0});
        random_burst(80);
        drain();

        // width above the legal range, zero root, five-level
        apb_write(REG_ROOT_BASE, 64'd0);
        apb_write(REG_PA_BITS, {58'd0, 6'h3F});
        apb_write(REG_FIVE_LEVEL, 64'd1);
        random_burst(80);
        drain();

        // random legal settings
        apb_write(REG_ROOT_BASE, rand64());
        apb_write(REG_PA_BITS, 64'($urandom_range(51, 33)));
        apb_write(REG_FIVE_LEVEL, 64'($urandom_range(1, 0)));
        random_burst(80);
        drain();

        if (mismatches == 0)
        begin
            $display("[page_table_walk_and_map] OK");
        end
        else
        begin
            $display("[page_table_walk_and_map] ERROR");
        end
        $finish;
    end

endmodule
